// ----- sv/rqms_pkg.sv -----
// rqms_pkg: shared record types, codes and key selection for the ready queue
`timescale 1ns / 1ps

package rqms_pkg;

  typedef struct packed {
    logic [15:0] proc_id;
    logic [31:0] arrival_time;
    logic [31:0] total_burst;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] remaining_burst;
    logic [7:0]  priority_level;
  } rec_t;

  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctl_t;

  localparam logic KIND_ENQ  = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  localparam logic [1:0] MODE_PRIO    = 2'd0;
  localparam logic [1:0] MODE_REMAIN  = 2'd1;
  localparam logic [1:0] MODE_ARRIVAL = 2'd2;
  // unused code, behaves as the priority key
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  function automatic logic [31:0] key_of(input rec_t r, input logic [1:0] mode);
    logic [31:0] k;
    case (mode)
      MODE_REMAIN:  k = r.remaining_burst;
      MODE_ARRIVAL: k = r.arrival_time;
      default:      k = {24'd0, r.priority_level};
    endcase
    return k;
  endfunction

endpackage

// ----- sv/rqms_cell.sv -----
// rqms_cell: one queue slot plus one stage of the running-minimum chain
`timescale 1ns / 1ps

module rqms_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  rqms_pkg::cell_ctl_t ctl,
  input  logic [1:0]         mode,
  input  rqms_pkg::rec_t     load_rec,
  input  rqms_pkg::rec_t     next_rec,
  input  logic               cand_vld_in,
  input  rqms_pkg::rec_t     cand_rec_in,
  input  logic [IDX_W-1:0]   cand_idx_in,
  output rqms_pkg::rec_t     slot_rec,
  output logic               cand_vld_out,
  output rqms_pkg::rec_t     cand_rec_out,
  output logic [IDX_W-1:0]   cand_idx_out
);
  import rqms_pkg::*;

  logic take_own;

  // strict less keeps the earlier record on a tie
  assign take_own = ctl.occupied &&
                    (!cand_vld_in || (key_of(slot_rec, mode) < key_of(cand_rec_in, mode)));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot_rec <= load_rec;
    end else if (ctl.shift) begin
      slot_rec <= next_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_vld_out <= 1'b0;
    end else begin
      cand_vld_out <= cand_vld_in || take_own;
    end
    if (take_own) begin
      cand_rec_out <= slot_rec;
      cand_idx_out <= IDX_W'(INDEX);
    end else begin
      cand_rec_out <= cand_rec_in;
      cand_idx_out <= cand_idx_in;
    end
  end

endmodule

// ----- sv/ready_queue_min_select.sv -----
// ready_queue_min_select: top level of the minimum-select ready queue
`timescale 1ns / 1ps
// Usage: an item is taken when start is high and busy is low. kind 0 appends
// the record on the input ports at the tail (status full and the record is
// dropped when QUEUE_DEPTH records are held); kind 1 removes the record with
// the least key, chosen by the 2-bit mode written through cfg_we / cfg_data
// (0 priority, 1 remaining burst, 2 arrival; 3 acts as 0). Ties go to the
// earlier record. The result shows for one cycle with done high, and the
// receiver has no way to hold it off.
// An enqueue, or a take on an empty queue, gives its result in the
// cycle after it is taken and busy stays low, so one item per cycle.
// A take on a non-empty queue holds busy high while the running minimum
// walks the row of slot cells one cell per cycle; done is registered in the
// last step of the scan, and the slots behind the winner move up in the
// same edge. A new item can be taken in the cycle that done is high.
// Reset (rst, synchronous) empties the queue and sets the mode to 0; slot
// contents are not cleared and are never read before they are written.
// Write the mode only while no item is in flight.

module ready_queue_min_select #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] proc_id,
  input  logic [31:0] arrival_time,
  input  logic [31:0] total_burst,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  input  logic [31:0] remaining_burst,
  input  logic [7:0]  priority_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] out_id,
  output logic [31:0] out_arrival,
  output logic [31:0] out_total_burst,
  output logic [31:0] out_start,
  output logic [31:0] out_end,
  output logic [31:0] out_remaining,
  output logic [7:0]  out_priority,
  output logic [4:0]  occupancy
);
  import rqms_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state;
  logic [1:0]       mode;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  rec_t             res_rec;

  logic             accept;
  logic             take_now;
  rec_t             new_rec;
  rec_t             best_rec;
  logic [IDX_W-1:0] best_idx;

  rec_t             slot_rec [QUEUE_DEPTH];
  rec_t             cand_rec [QUEUE_DEPTH];
  logic [IDX_W-1:0] cand_idx [QUEUE_DEPTH];
  logic             cand_vld [QUEUE_DEPTH];
  cell_ctl_t        ctl      [QUEUE_DEPTH];

  assign busy     = (state == S_SCAN);
  assign accept   = start && !busy;
  assign take_now = (state == S_SCAN) && (step == LAST_STEP);
  assign best_rec = cand_rec[QUEUE_DEPTH-1];
  assign best_idx = cand_idx[QUEUE_DEPTH-1];

  assign new_rec = '{proc_id: proc_id, arrival_time: arrival_time,
                     total_burst: total_burst, start_time: start_time,
                     end_time: end_time, remaining_burst: remaining_burst,
                     priority_level: priority_level};

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic             vld_in;
      rec_t             rec_in;
      logic [IDX_W-1:0] idx_in;
      rec_t             nxt;

      assign ctl[i].occupied = (CNT_W'(i) < count);
      assign ctl[i].load     = accept && (kind == KIND_ENQ) && (count == CNT_W'(i));
      assign ctl[i].shift    = take_now && (IDX_W'(i) >= best_idx);

      if (i == 0) begin : g_head
        assign vld_in = 1'b0;
        assign rec_in = '0;
        assign idx_in = '0;
      end else begin : g_body
        assign vld_in = cand_vld[i-1];
        assign rec_in = cand_rec[i-1];
        assign idx_in = cand_idx[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = slot_rec[i+1];
      end

      rqms_cell #(
        .INDEX (i),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctl          (ctl[i]),
        .mode         (mode),
        .load_rec     (new_rec),
        .next_rec     (nxt),
        .cand_vld_in  (vld_in),
        .cand_rec_in  (rec_in),
        .cand_idx_in  (idx_in),
        .slot_rec     (slot_rec[i]),
        .cand_vld_out (cand_vld[i]),
        .cand_rec_out (cand_rec[i]),
        .cand_idx_out (cand_idx[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_PRIO;
      count <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        mode <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_ENQ) begin
              done    <= 1'b1;
              res_rec <= '0;
              if (count == DEPTH_CNT) begin
                status    <= ST_FULL;
                occupancy <= 5'(count);
              end else begin
                status    <= ST_OK;
                count     <= count + CNT_W'(1);
                occupancy <= 5'(count + CNT_W'(1));
              end
            end else if (count == '0) begin
              done      <= 1'b1;
              status    <= ST_EMPTY;
              res_rec   <= '0;
              occupancy <= 5'd0;
            end else begin
              state <= S_SCAN;
              step  <= '0;
            end
          end
        end
        S_SCAN: begin
          if (take_now) begin
            done      <= 1'b1;
            status    <= ST_OK;
            res_rec   <= best_rec;
            count     <= count - CNT_W'(1);
            occupancy <= 5'(count - CNT_W'(1));
            state     <= S_IDLE;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_id          = res_rec.proc_id;
  assign out_arrival     = res_rec.arrival_time;
  assign out_total_burst = res_rec.total_burst;
  assign out_start       = res_rec.start_time;
  assign out_end         = res_rec.end_time;
  assign out_remaining   = res_rec.remaining_burst;
  assign out_priority    = res_rec.priority_level;

  a_scan_only_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (kind == KIND_TAKE) && (count != '0)))
    else $error("scan started without a take on a non-empty queue");

  a_take_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_TAKE) && (count != '0)) |-> ##(QUEUE_DEPTH + 1) done)
    else $error("take result not delivered on time");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scanning an empty queue");

  a_winner_valid: assert property (@(posedge clk) disable iff (rst)
    take_now |-> (cand_vld[QUEUE_DEPTH-1] && (CNT_W'(best_idx) < count)))
    else $error("selected slot is not occupied");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (count == DEPTH_CNT))
    else $error("full reported while the queue has room");

endmodule
